>>> hw/rtl/affine_warp_bilinear_assert.svh
// assertion macros shared by the warp block
`ifndef AFFINE_WARP_BILINEAR_ASSERT_SVH
`define AFFINE_WARP_BILINEAR_ASSERT_SVH

// condition must hold on every clock out of reset
`define AWB_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("awb invariant broken");

// antecedent implies consequent in the same cycle
`define AWB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awb implication broken");

`endif

>>> hw/rtl/awb_pkg.sv
package awb_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_OVER_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_OVER_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd5;

  localparam logic [15:0] RST_COS_OVER_SCALE = 16'd4096;
  localparam logic [5:0]  RST_IMAGE_SIZE     = 6'd28;

  // half of one output lsb after the blend, and the top of the pixel range
  localparam logic [24:0] ROUND_HALF = 25'd32768;
  localparam logic [7:0]  PIX_MAX    = 8'd255;

  // queue depths, powers of two
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 8;

  typedef struct packed {
    logic [15:0] shift_x;
    logic [15:0] shift_y;
    logic [15:0] cos_over_scale;
    logic [15:0] sin_over_scale;
    logic [5:0]  image_width;
    logic [5:0]  image_height;
  } cfg_t;

  // one classified item from the front to the back
  typedef struct packed {
    logic       op;
    logic       wr_en;
    logic [1:0] bank;
    logic [7:0] value;
    logic [3:0] mask;
    logic       px;
    logic       py;
    logic [7:0] wx;
    logic [7:0] wy;
  } job_t;

  // address bits of one parity bank along an axis of n pixels
  function automatic int half_bits(input int n);
    int half;
    half = (n + 1) >> 1;
    return (half > 1) ? $clog2(half) : 1;
  endfunction

endpackage

>>> hw/rtl/awb_fifo.sv
module awb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int PW = $clog2(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [LW-1:0]    level
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             take;

  assign take  = pop && !empty;
  assign empty = (level == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + LW'(push) - LW'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

>>> hw/rtl/awb_front.sv
module awb_front import awb_pkg::*; #(
  parameter int MAX_WIDTH = 32,
  parameter int MAX_HEIGHT = 32,
  localparam int HXB = half_bits(MAX_WIDTH),
  localparam int HYB = half_bits(MAX_HEIGHT),
  localparam int AW = HXB + HYB
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                accept,
  input  logic                operation,
  input  logic [4:0]          pixel_col,
  input  logic [4:0]          pixel_row,
  input  logic [7:0]          write_value,
  output logic                job_valid,
  output job_t                job,
  output logic [3:0][AW-1:0]  job_addr,
  output logic [1:0]          inflight
);

  // sizes clipped to the store, and the image centre in q5.8
  logic [5:0]  w_eff, h_eff, wm1, hm1;
  logic        size_zero;
  logic [12:0] cx, cy;

  assign w_eff = ({3'b0, cfg.image_width} > 9'(MAX_WIDTH)) ? 6'(MAX_WIDTH)
                                                           : cfg.image_width;
  assign h_eff = ({3'b0, cfg.image_height} > 9'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT)
                                                             : cfg.image_height;
  assign wm1 = w_eff - 6'd1;
  assign hm1 = h_eff - 6'd1;
  assign size_zero = (w_eff == 6'd0) || (h_eff == 6'd0);
  assign cx = {wm1, 7'b0};
  assign cy = {hm1, 7'b0};

  // stage a: offset from the centre and the shift
  logic signed [16:0] rx_in, ry_in;

  assign rx_in = $signed({4'b0, pixel_col, 8'b0}) - $signed({4'b0, cx})
               - 17'($signed(cfg.shift_x));
  assign ry_in = $signed({4'b0, pixel_row, 8'b0}) - $signed({4'b0, cy})
               - 17'($signed(cfg.shift_y));

  logic               a_valid, b_valid, c_valid;
  logic               a_op, b_op, c_op;
  logic [4:0]         a_col, b_col, c_col;
  logic [4:0]         a_row, b_row, c_row;
  logic [7:0]         a_value, b_value, c_value;
  logic signed [16:0] a_rx, a_ry;
  logic signed [32:0] b_pcx, b_psy, b_pcy, b_psx;
  logic signed [21:0] c_mx, c_my;
  logic signed [33:0] sum_x, sum_y;

  assign sum_x = 34'(b_pcx) + 34'(b_psy);
  assign sum_y = 34'(b_pcy) - 34'(b_psx);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_op    <= operation;
    a_col   <= pixel_col;
    a_row   <= pixel_row;
    a_value <= write_value;
    a_rx    <= rx_in;
    a_ry    <= ry_in;

    b_op    <= a_op;
    b_col   <= a_col;
    b_row   <= a_row;
    b_value <= a_value;
    b_pcx   <= 33'(a_rx) * 33'($signed(cfg.cos_over_scale));
    b_psy   <= 33'(a_ry) * 33'($signed(cfg.sin_over_scale));
    b_pcy   <= 33'(a_ry) * 33'($signed(cfg.cos_over_scale));
    b_psx   <= 33'(a_rx) * 33'($signed(cfg.sin_over_scale));

    c_op    <= b_op;
    c_col   <= b_col;
    c_row   <= b_row;
    c_value <= b_value;
    // floor shift by 12 keeps eight fraction bits
    c_mx    <= sum_x[33:12];
    c_my    <= sum_y[33:12];
  end

  // stage d: back to source coordinates, range test, bank addresses
  logic signed [22:0] sx, sy, lim_x, lim_y;
  logic [5:0]         x0, y0;
  logic [5:0]         hx0, hx1, hy0, hy1;
  logic               in_image, x_next_ok, y_next_ok;

  assign sx    = $signed({c_mx[21], c_mx}) + $signed({10'b0, cx});
  assign sy    = $signed({c_my[21], c_my}) + $signed({10'b0, cy});
  assign lim_x = $signed({9'b0, wm1, 8'b0});
  assign lim_y = $signed({9'b0, hm1, 8'b0});

  assign in_image = !size_zero && !sx[22] && !sy[22] && (sx <= lim_x) && (sy <= lim_y);
  assign x0 = sx[13:8];
  assign y0 = sy[13:8];
  assign x_next_ok = (x0 < wm1);
  assign y_next_ok = (y0 < hm1);

  // odd bank holds x0 or x0+1 at the same half index; even bank steps on odd x0
  assign hx1 = {1'b0, x0[5:1]};
  assign hx0 = {1'b0, x0[5:1]} + {5'b0, x0[0]};
  assign hy1 = {1'b0, y0[5:1]};
  assign hy0 = {1'b0, y0[5:1]} + {5'b0, y0[0]};

  always_comb begin
    job.op    = c_op;
    job.wr_en = ({4'b0, c_col} < 9'(MAX_WIDTH)) && ({4'b0, c_row} < 9'(MAX_HEIGHT));
    job.bank  = {c_row[0], c_col[0]};
    job.value = c_value;
    job.mask  = {in_image && x_next_ok && y_next_ok, in_image && y_next_ok,
                 in_image && x_next_ok, in_image};
    job.px    = x0[0];
    job.py    = y0[0];
    job.wx    = sx[7:0];
    job.wy    = sy[7:0];
    for (int b = 0; b < 4; b++) begin
      if (c_op == OP_SAMPLE) begin
        job_addr[b] = {HYB'(b[1] ? hy1 : hy0), HXB'(b[0] ? hx1 : hx0)};
      end else begin
        job_addr[b] = {HYB'(c_row[4:1]), HXB'(c_col[4:1])};
      end
    end
  end

  assign job_valid = c_valid;
  assign inflight  = {1'b0, a_valid} + {1'b0, b_valid} + {1'b0, c_valid};

endmodule

>>> hw/rtl/awb_back.sv
module awb_back import awb_pkg::*; #(
  parameter int MAX_WIDTH = 32,
  parameter int MAX_HEIGHT = 32,
  localparam int HXB = half_bits(MAX_WIDTH),
  localparam int HYB = half_bits(MAX_HEIGHT),
  localparam int AW = HXB + HYB,
  localparam int BANK_DEPTH = 1 << AW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               issue,
  input  job_t               job,
  input  logic [3:0][AW-1:0] job_addr,
  output logic               res_valid,
  output logic [7:0]         res_pixel,
  output logic [1:0]         inflight
);

  // four parity banks, one per (row parity, column parity)
  logic [7:0] rd_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (issue && (job.op == OP_WRITE) && job.wr_en && (job.bank == 2'(b))) begin
        mem[job_addr[b]] <= job.value;
      end
      rd_q[b] <= mem[job_addr[b]];
    end
  end

  logic        s1_valid, s2_valid, s3_valid;
  logic [3:0]  s1_mask;
  logic        s1_px, s1_py;
  logic [7:0]  s1_wx, s1_wy, s2_wy;
  logic [15:0] s2_v0, s2_v1;
  logic [23:0] s3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue && (job.op == OP_SAMPLE);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // neighbours in order 00, 10, 01, 11 (bit 0 steps x, bit 1 steps y)
  logic [7:0]         nb [4];
  logic signed [8:0]  d_top, d_bot;
  logic signed [17:0] row_top, row_bot;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      nb[n] = s1_mask[n] ? rd_q[{s1_py ^ n[1], s1_px ^ n[0]}] : 8'd0;
    end
  end

  assign d_top   = $signed({1'b0, nb[1]}) - $signed({1'b0, nb[0]});
  assign d_bot   = $signed({1'b0, nb[3]}) - $signed({1'b0, nb[2]});
  assign row_top = $signed({2'b0, nb[0], 8'b0})
                 + 18'(d_top) * 18'($signed({1'b0, s1_wx}));
  assign row_bot = $signed({2'b0, nb[2], 8'b0})
                 + 18'(d_bot) * 18'($signed({1'b0, s1_wx}));

  logic signed [16:0] d_col;
  logic signed [25:0] mix;

  assign d_col = $signed({1'b0, s2_v1}) - $signed({1'b0, s2_v0});
  assign mix   = $signed({2'b0, s2_v0, 8'b0})
               + 26'(d_col) * 26'($signed({1'b0, s2_wy}));

  always_ff @(posedge clk) begin
    s1_mask <= job.mask;
    s1_px   <= job.px;
    s1_py   <= job.py;
    s1_wx   <= job.wx;
    s1_wy   <= job.wy;

    s2_v0   <= row_top[15:0];
    s2_v1   <= row_bot[15:0];
    s2_wy   <= s1_wy;

    s3_v    <= mix[23:0];
  end

  // round half up, then clamp
  logic [24:0] rounded;

  assign rounded   = {1'b0, s3_v} + ROUND_HALF;
  assign res_pixel = (rounded[24:16] > {1'b0, PIX_MAX}) ? PIX_MAX : rounded[23:16];
  assign res_valid = s3_valid;
  assign inflight  = {1'b0, s1_valid} + {1'b0, s2_valid} + {1'b0, s3_valid};

endmodule

>>> hw/rtl/affine_warp_bilinear.sv
// Affine warp with bilinear sampling over a parity-banked frame store.
// Input side is a queue: an item is taken at a clock edge with push high and
// full low. operation selects a pixel write (write_value stored at
// pixel_col, pixel_row) or a sample of that destination coordinate.
// Result side is a queue: while empty is low, warped_pixel holds the oldest
// result and it is taken at an edge with pop high. Write items give no result.
// Configuration registers are written through cfg_write, cfg_addr, cfg_data.
// The user must write them only while no item is in flight; nothing enforces it.
// Throughput is one item per cycle while full stays low. A sample result
// passes three front stages (centre offset, the four products, the sum and
// floor shift), the mid queue, the registered bank read, and two blend
// stages; the rounding feeds the result queue.
// The four neighbours come from four banks in the same cycle, so reads never
// contend. A write lands in the store when it is issued from the mid queue,
// in order with the samples around it.
// If pop stays low, the result queue fills and full rises once the credits
// for in-flight items run out; nothing is dropped.
// Reset clears the queues, the pipeline and the registers to their defaults;
// the frame store keeps whatever it held.
`include "affine_warp_bilinear_assert.svh"

module affine_warp_bilinear import awb_pkg::*; #(
  parameter int MAX_WIDTH = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  operation,
  input  logic [4:0]            pixel_col,
  input  logic [4:0]            pixel_row,
  input  logic [7:0]            write_value,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            warped_pixel,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = half_bits(MAX_WIDTH) + half_bits(MAX_HEIGHT);
  localparam int JBW = $bits(job_t);
  localparam int JW  = JBW + 4 * AW;
  localparam int MLW = $clog2(MID_DEPTH + 1);
  localparam int OLW = $clog2(OUT_DEPTH + 1);
  localparam int MUW = MLW + 1;
  localparam int OUW = OLW + 1;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shift_x        <= '0;
      cfg.shift_y        <= '0;
      cfg.cos_over_scale <= RST_COS_OVER_SCALE;
      cfg.sin_over_scale <= '0;
      cfg.image_width    <= RST_IMAGE_SIZE;
      cfg.image_height   <= RST_IMAGE_SIZE;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_SHIFT_X:        cfg.shift_x        <= cfg_data;
        REG_SHIFT_Y:        cfg.shift_y        <= cfg_data;
        REG_COS_OVER_SCALE: cfg.cos_over_scale <= cfg_data;
        REG_SIN_OVER_SCALE: cfg.sin_over_scale <= cfg_data;
        REG_IMAGE_WIDTH:    cfg.image_width    <= cfg_data[5:0];
        REG_IMAGE_HEIGHT:   cfg.image_height   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic               accept;
  logic               front_push;
  job_t               front_job;
  logic [3:0][AW-1:0] front_addr;
  logic [1:0]         front_inflight;
  logic [JW-1:0]      mid_dout;
  logic               mid_empty;
  logic [MLW-1:0]     mid_level;
  logic [MUW-1:0]     mid_used;
  logic               issue;
  job_t               mid_job;
  logic [3:0][AW-1:0] mid_addr;
  logic               back_push;
  logic [7:0]         back_pixel;
  logic [1:0]         back_inflight;
  logic [OLW-1:0]     out_level;
  logic [OUW-1:0]     out_used;

  // credits: queue contents plus what is still in the stages feeding it
  assign mid_used = MUW'(mid_level) + MUW'(front_inflight);
  assign out_used = OUW'(out_level) + OUW'(back_inflight);
  assign full     = (mid_used >= MUW'(MID_DEPTH));
  assign accept   = push && !full;
  assign issue    = !mid_empty && (out_used < OUW'(OUT_DEPTH));

  awb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .operation   (operation),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .write_value (write_value),
    .job_valid   (front_push),
    .job         (front_job),
    .job_addr    (front_addr),
    .inflight    (front_inflight)
  );

  awb_fifo #(
    .WIDTH (JW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .din   ({front_addr, front_job}),
    .pop   (issue),
    .dout  (mid_dout),
    .empty (mid_empty),
    .level (mid_level)
  );

  assign mid_job  = mid_dout[JBW-1:0];
  assign mid_addr = mid_dout[JW-1:JBW];

  awb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .job       (mid_job),
    .job_addr  (mid_addr),
    .res_valid (back_push),
    .res_pixel (back_pixel),
    .inflight  (back_inflight)
  );

  awb_fifo #(
    .WIDTH (8),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .din   (back_pixel),
    .pop   (pop),
    .dout  (warped_pixel),
    .empty (empty),
    .level (out_level)
  );

  `AWB_ASSERT_ALWAYS(a_mid_credit, mid_used <= MUW'(MID_DEPTH))
  `AWB_ASSERT_ALWAYS(a_out_credit, out_used <= OUW'(OUT_DEPTH))
  `AWB_ASSERT_IMPLY(a_mid_room, front_push, mid_level < MLW'(MID_DEPTH))
  `AWB_ASSERT_IMPLY(a_out_room, back_push, out_level < OLW'(OUT_DEPTH))

endmodule
